@@ hdl/cba_pkg.sv @@
`default_nettype none

package cba_pkg;

    localparam int NUM_BLOCKS_DEF  = 64;
    localparam int TABLE_DEPTH_DEF = 32;

    typedef enum logic [0:0] {
        OP_ALLOC  = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_ALLOCATED = 3'd0,
        ST_OVERLAP   = 3'd1,
        ST_RANGE     = 3'd2,
        ST_FULL      = 3'd3,
        ST_FOUND     = 3'd4,
        ST_MISSING   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANGE,
        S_CHECK,
        S_COMMIT,
        S_SCAN
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [5:0]  start_block;
        logic [6:0]  run_length;
        logic [15:0] query_file;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [15:0] assigned_file;
        logic [6:0]  found_length;
    } t_out_word;

    typedef struct packed {
        logic [15:0] rec_file;
        logic [6:0]  rec_length;
    } t_record;

endpackage

`default_nettype wire

@@ hdl/contiguous_block_allocator.sv @@
// Contiguous block allocator with a file table.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one word per
// request: op selects allocate or lookup. Output channel (o_out_valid /
// i_out_stall / o_out_data) returns exactly one word per request, in order.
// o_in_stall is high while a request is in progress; the block handles one
// request at a time.
// Allocate: every request takes the next file number. The range check comes
// first, then the bit probe walks the run one block per cycle, then the
// commit state writes the result to the output register. Lookup: the table
// memory is read one record per cycle, with the compare in the cycle after
// each read, up to the record count; a hit stops the scan early.
// The result sits in an output register, so a new request is accepted while
// the previous result waits; if the receiver stalls and the register is
// still full, the block holds its finished result until the register frees.
// Reset (synchronous, active low) frees every block, empties the table and
// sets the next file number to one. The table memory itself is not cleared:
// only entries below the record count are ever read.
`default_nettype none

module contiguous_block_allocator #(
    parameter int NUM_BLOCKS  = cba_pkg::NUM_BLOCKS_DEF,
    parameter int TABLE_DEPTH = cba_pkg::TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cba_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cba_pkg::t_out_word o_out_data
);
    import cba_pkg::*;

    localparam int BIW = $clog2(NUM_BLOCKS);
    localparam int CW  = ($clog2(NUM_BLOCKS + 1) > 7) ? $clog2(NUM_BLOCKS + 1) + 1 : 8;
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int NW  = $clog2(TABLE_DEPTH + 1);

    t_state                r_state, n_state;
    t_in_word              r_req, n_req;
    logic [15:0]           r_file, n_file;
    logic [15:0]           r_next_file, n_next_file;
    logic [NUM_BLOCKS-1:0] r_map, n_map;
    logic [NUM_BLOCKS-1:0] run_mask;
    logic [NW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_blk, n_blk;
    logic [6:0]            r_left, n_left;
    logic [CW-1:0]         r_end, n_end;
    logic [NW-1:0]         r_idx, n_idx;
    logic                  r_cmp_vld, n_cmp_vld;
    t_record               r_tab [TABLE_DEPTH];
    t_record               r_rd;
    logic                  mem_we, mem_re;
    logic                  r_out_vld;
    t_out_word             r_out, res;
    logic                  res_vld;
    logic                  out_free;
    logic                  hit;
    logic                  full;

    assign out_free    = !r_out_vld || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign hit  = r_cmp_vld && (r_rd.rec_file == r_req.query_file);
    assign full = (r_count == NW'(TABLE_DEPTH));

    always_comb begin
        for (int b = 0; b < NUM_BLOCKS; b++) begin
            run_mask[b] = (CW'(b) >= CW'(r_req.start_block)) && (CW'(b) < r_end);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_file      = r_file;
        n_next_file = r_next_file;
        n_map       = r_map;
        n_count     = r_count;
        n_blk       = r_blk;
        n_left      = r_left;
        n_end       = r_end;
        n_idx       = r_idx;
        n_cmp_vld   = r_cmp_vld;
        res_vld     = 1'b0;
        res         = '0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_in_data;
                    if (i_in_data.op == OP_ALLOC) begin
                        n_file      = r_next_file;
                        n_next_file = r_next_file + 16'd1;
                        n_state     = S_RANGE;
                    end else begin
                        n_idx     = '0;
                        n_cmp_vld = 1'b0;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_RANGE: begin
                n_blk  = CW'(r_req.start_block);
                n_left = r_req.run_length;
                n_end  = CW'(r_req.start_block) + CW'(r_req.run_length);
                if (n_end > CW'(NUM_BLOCKS)) begin
                    res_vld           = 1'b1;
                    res.status        = ST_RANGE;
                    res.assigned_file = r_file;
                    if (out_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_left == 7'd0) begin
                    n_state = S_COMMIT;
                end else if (r_map[r_blk[BIW-1:0]]) begin
                    res_vld           = 1'b1;
                    res.status        = ST_OVERLAP;
                    res.assigned_file = r_file;
                    if (out_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_blk  = r_blk + CW'(1);
                    n_left = r_left - 7'd1;
                end
            end
            S_COMMIT: begin
                res_vld           = 1'b1;
                res.status        = full ? ST_FULL : ST_ALLOCATED;
                res.assigned_file = r_file;
                if (out_free) begin
                    n_state = S_IDLE;
                    if (!full) begin
                        mem_we  = 1'b1;
                        n_map   = r_map | run_mask;
                        n_count = r_count + NW'(1);
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    res_vld          = 1'b1;
                    res.status       = ST_FOUND;
                    res.found_length = r_rd.rec_length;
                    if (out_free) begin
                        n_state = S_IDLE;
                    end
                end else if (r_idx == r_count && !r_cmp_vld) begin
                    res_vld    = 1'b1;
                    res.status = ST_MISSING;
                    if (out_free) begin
                        n_state = S_IDLE;
                    end
                end else if (r_idx < r_count) begin
                    // read the next record, compare it on the following cycle
                    mem_re    = 1'b1;
                    n_idx     = r_idx + NW'(1);
                    n_cmp_vld = 1'b1;
                end else begin
                    n_cmp_vld = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_file <= 16'd1;
            r_map       <= '0;
            r_count     <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_file <= n_next_file;
            r_map       <= n_map;
            r_count     <= n_count;
            r_cmp_vld   <= n_cmp_vld;
            if (res_vld && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_file <= n_file;
        r_blk  <= n_blk;
        r_left <= n_left;
        r_end  <= n_end;
        r_idx  <= n_idx;
        if (res_vld && out_free) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tab[r_count[AW-1:0]] <= '{rec_file: r_file, rec_length: r_req.run_length};
        end
        if (mem_re) begin
            r_rd <= r_tab[r_idx[AW-1:0]];
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(TABLE_DEPTH))
        else $error("record count past table depth");

    a_commit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && out_free && !full) |=> (r_count == $past(r_count) + NW'(1)))
        else $error("commit did not append a record");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_count))
        else $error("scan index past record count");

    a_map_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (($past(r_map) & ~r_map) == '0))
        else $error("used block freed without reset");

endmodule

`default_nettype wire
